// ===== design/assert_macros.svh =====
// assertion macros used by the hash set design file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property checked on every rising clock edge outside reset
`define QPHS_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// condition that must hold in the cycle after a trigger
`define QPHS_ASSERT_NEXT(lbl, pre, post, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) else $error(msg);

`endif

// ===== design/qphs_pkg.sv =====
// types and constants for the quadratic probe hash set
`timescale 1ns / 1ps

package qphs_pkg;

  localparam int KEY_BITS   = 32;
  localparam int SIZE_W     = 8;
  localparam int SLOT_W     = 7;
  localparam int COUNT_W    = 8;
  localparam int DIGIT_BITS = 4;
  localparam int MOD_STEPS  = KEY_BITS / DIGIT_BITS;

  localparam logic [SIZE_W-1:0]  SIZE_RESET = 8'd101;
  localparam logic [COUNT_W-1:0] COUNT_MAX  = 8'd255;

  typedef enum logic [1:0] {
    KIND_LOOKUP = 2'd0,
    KIND_INSERT = 2'd1,
    KIND_REMOVE = 2'd2,
    KIND_CLEAR  = 2'd3
  } kind_t;

  typedef enum logic [1:0] {
    STATUS_OK      = 2'd0,
    STATUS_REFUSED = 2'd1,
    STATUS_NO_SLOT = 2'd2
  } status_t;

  typedef enum logic [1:0] {
    MARK_EMPTY   = 2'd0,
    MARK_ACTIVE  = 2'd1,
    MARK_DELETED = 2'd2
  } mark_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MOD,
    ST_READ,
    ST_CHECK,
    ST_PUSH
  } state_t;

endpackage

// ===== design/qphs_ram.sv =====
// generic single write port ram with registered read
`timescale 1ns / 1ps

module qphs_ram #(
  parameter int WIDTH = 34,
  parameter int DEPTH = 128
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // registered read port
  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

// ===== design/qphs_mod.sv =====
// iterative key modulo table size, four dividend bits per cycle
`timescale 1ns / 1ps

module qphs_mod import qphs_pkg::*; (
  input  logic                clk,
  input  logic                rst,
  input  logic                start,
  input  logic [KEY_BITS-1:0] dividend,
  input  logic [SIZE_W-1:0]   divisor,
  output logic                done,
  output logic [SIZE_W-1:0]   remainder
);

  localparam int CNT_W = $clog2(MOD_STEPS);

  logic             busy;
  logic [CNT_W-1:0] cnt;
  logic [KEY_BITS-1:0] shreg;
  logic [SIZE_W-1:0]   rem_next;
  logic [SIZE_W-1:0]   rem_tmp;
  logic [SIZE_W:0]     trial;

  // restoring steps over the next few dividend bits
  always_comb begin
    rem_tmp = remainder;
    trial   = '0;
    for (int k = 0; k < DIGIT_BITS; k++) begin
      trial = {rem_tmp, shreg[KEY_BITS-1-k]};
      if (trial >= {1'b0, divisor}) begin
        trial = trial - {1'b0, divisor};
      end
      rem_tmp = trial[SIZE_W-1:0];
    end
    rem_next = rem_tmp;
  end

  // step counter and done pulse
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= '0;
      end else if (busy) begin
        cnt <= cnt + 1'b1;
        if (cnt == CNT_W'(MOD_STEPS - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  // dividend shifter and partial remainder
  always_ff @(posedge clk) begin
    if (start) begin
      shreg     <= dividend;
      remainder <= '0;
    end else if (busy) begin
      shreg     <= shreg << DIGIT_BITS;
      remainder <= rem_next;
    end
  end

endmodule

// ===== design/quadratic_probe_hash_set.sv =====
// hash set of keys with open addressing and quadratic probing
//
//   channel   direction  handshake              payload
//   request   in         in_valid / in_stall    kind, key
//   result    out        out_valid / out_stall  status, slot, fill_count, over_half
//   config    in         cfg_valid / cfg_ready  table_size
//
// a lookup, insert or remove waits in ST_MOD for the remainder unit and its done
// pulse, then takes one ram read (ST_READ) and one compare (ST_CHECK) per probe,
// and ends in ST_PUSH. a clear goes straight to ST_PUSH. slot marks sit in ram
// with a flip-flop valid bit per slot, so reset and clear take effect at once
// with no sweep of the ram.
// a finished result waits in the output register; the next request is taken
// while it waits, and only the hand-over of a later result stalls behind it.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module quadratic_probe_hash_set import qphs_pkg::*; #(
  parameter int TABLE_DEPTH = 128,
  parameter int KEY_WIDTH   = 32
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_stall,
  input  logic [1:0]          kind,
  input  logic [KEY_BITS-1:0] key,
  output logic                out_valid,
  input  logic                out_stall,
  output logic [1:0]          status,
  output logic [SLOT_W-1:0]   slot,
  output logic [COUNT_W-1:0]  fill_count,
  output logic                over_half,
  input  logic                cfg_valid,
  output logic                cfg_ready,
  input  logic [SIZE_W-1:0]   table_size
);

  localparam int ADDR_W    = $clog2(TABLE_DEPTH);
  localparam int STORE_W   = (KEY_WIDTH < KEY_BITS) ? KEY_WIDTH : KEY_BITS;
  localparam int RAM_W     = STORE_W + 2;
  localparam int VALID_N   = (TABLE_DEPTH > 256) ? 256 : TABLE_DEPTH;
  localparam int VALID_W   = $clog2(VALID_N);
  localparam int MAX_SIZE_I = (TABLE_DEPTH > 255) ? 255 : TABLE_DEPTH;
  localparam logic [SIZE_W-1:0]   MAX_SIZE = SIZE_W'(MAX_SIZE_I);
  localparam logic [KEY_BITS-1:0] KEY_MASK = {KEY_BITS{1'b1}} >> (KEY_BITS - STORE_W);

  state_t state, state_next;

  logic [SIZE_W-1:0]   size_cfg;
  logic [SIZE_W-1:0]   size_eff;
  logic [SIZE_W-1:0]   half;
  logic [COUNT_W-1:0]  insert_count;
  logic [VALID_N-1:0]  slot_valid;

  kind_t               op_kind;
  logic [KEY_BITS-1:0] op_key;
  logic [SIZE_W-1:0]   pos;
  logic [SIZE_W:0]     offset;
  logic [SIZE_W-1:0]   probe_cnt;
  status_t             res_status;

  logic [SIZE_W:0]     pos_sum;
  logic [SIZE_W-1:0]   pos_step;
  logic                mod_start;
  logic                mod_done;
  logic [SIZE_W-1:0]   mod_rem;
  logic [KEY_BITS-1:0] key_masked;

  logic                ram_we;
  logic [RAM_W-1:0]    ram_wdata;
  logic [RAM_W-1:0]    ram_rdata;
  logic [ADDR_W-1:0]   ram_addr;

  mark_t               mark;
  logic                hit;
  logic                active;
  logic                last_probe;
  status_t             check_status;
  logic                accept;
  logic                out_free;
  logic                push_load;
  logic                probing;
  logic                clear_take;

  assign cfg_ready  = 1'b1;
  assign in_stall   = (state != ST_IDLE);
  assign accept     = in_valid && !in_stall;
  assign key_masked = key & KEY_MASK;
  assign out_free   = !out_valid || !out_stall;
  assign push_load  = (state == ST_PUSH) && out_free;
  assign probing    = (state == ST_READ) || (state == ST_CHECK);
  assign clear_take = accept && (kind == KIND_CLEAR);

  // table size clamped to the usable range
  always_comb begin
    if (size_cfg == '0) begin
      size_eff = SIZE_W'(1);
    end else if (size_cfg > MAX_SIZE) begin
      size_eff = MAX_SIZE;
    end else begin
      size_eff = size_cfg;
    end
  end

  assign half = size_eff >> 1;

  // home slot from the remainder unit
  qphs_mod u_mod (
    .clk       (clk),
    .rst       (rst),
    .start     (mod_start),
    .dividend  (key_masked),
    .divisor   (size_eff),
    .done      (mod_done),
    .remainder (mod_rem)
  );

  // slot store: mark over key
  assign ram_addr = ADDR_W'(pos);

  qphs_ram #(
    .WIDTH (RAM_W),
    .DEPTH (TABLE_DEPTH)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_addr),
    .wdata (ram_wdata),
    .raddr (ram_addr),
    .rdata (ram_rdata)
  );

  // probe compare on the slot just read
  always_comb begin
    mark       = slot_valid[pos[VALID_W-1:0]] ? mark_t'(ram_rdata[RAM_W-1 -: 2]) : MARK_EMPTY;
    hit        = (mark == MARK_EMPTY) || (ram_rdata[STORE_W-1:0] == op_key[STORE_W-1:0]);
    active     = (mark == MARK_ACTIVE);
    last_probe = (probe_cnt == half);
    if (!hit) begin
      check_status = STATUS_NO_SLOT;
    end else begin
      case (op_kind)
        KIND_INSERT: check_status = active ? STATUS_REFUSED : STATUS_OK;
        default:     check_status = active ? STATUS_OK : STATUS_REFUSED;
      endcase
    end
  end

  // write back on a successful insert or remove
  always_comb begin
    ram_we    = (state == ST_CHECK) && hit &&
                (((op_kind == KIND_INSERT) && !active) || ((op_kind == KIND_REMOVE) && active));
    ram_wdata = {((op_kind == KIND_INSERT) ? MARK_ACTIVE : MARK_DELETED), op_key[STORE_W-1:0]};
  end

  // next probe position, wrapped once
  always_comb begin
    pos_sum  = {1'b0, pos} + offset;
    pos_step = (pos_sum >= {1'b0, size_eff}) ? SIZE_W'(pos_sum - {1'b0, size_eff})
                                              : pos_sum[SIZE_W-1:0];
  end

  // state register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // next state and remainder start
  always_comb begin
    state_next = state;
    mod_start  = 1'b0;
    unique case (state)
      ST_IDLE: begin
        if (in_valid) begin
          if (kind == KIND_CLEAR) begin
            state_next = ST_PUSH;
          end else begin
            state_next = ST_MOD;
            mod_start  = 1'b1;
          end
        end
      end
      ST_MOD: begin
        if (mod_done) begin
          state_next = ST_READ;
        end
      end
      ST_READ: begin
        state_next = ST_CHECK;
      end
      ST_CHECK: begin
        state_next = (hit || last_probe) ? ST_PUSH : ST_READ;
      end
      ST_PUSH: begin
        if (out_free) begin
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  // config, fill count, valid bits and output valid
  always_ff @(posedge clk) begin
    if (rst) begin
      size_cfg     <= SIZE_RESET;
      insert_count <= '0;
      slot_valid   <= '0;
      out_valid    <= 1'b0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        size_cfg <= table_size;
      end
      if (accept && (kind == KIND_CLEAR)) begin
        insert_count <= '0;
        slot_valid   <= '0;
      end else if (ram_we && (op_kind == KIND_INSERT)) begin
        slot_valid[pos[VALID_W-1:0]] <= 1'b1;
        if (insert_count != COUNT_MAX) begin
          insert_count <= insert_count + 1'b1;
        end
      end
      if (push_load) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  // request registers and probe walk
  always_ff @(posedge clk) begin
    if (accept) begin
      op_kind    <= kind_t'(kind);
      op_key     <= key_masked;
      pos        <= '0;
      res_status <= STATUS_OK;
    end else if ((state == ST_MOD) && mod_done) begin
      pos       <= mod_rem;
      offset    <= (SIZE_W + 1)'(1);
      probe_cnt <= '0;
    end else if (state == ST_CHECK) begin
      if (hit || last_probe) begin
        res_status <= check_status;
      end else begin
        pos       <= pos_step;
        offset    <= offset + (SIZE_W + 1)'(2);
        probe_cnt <= probe_cnt + 1'b1;
      end
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (push_load) begin
      status     <= res_status;
      slot       <= pos[SLOT_W-1:0];
      fill_count <= insert_count;
      over_half  <= (insert_count > half);
    end
  end

  `QPHS_ASSERT(a_pos_in_range, probing |-> (pos < size_eff), "probe position outside table")
  `QPHS_ASSERT(a_probe_bound, (state == ST_CHECK) |-> (probe_cnt <= half), "probe past bound")
  `QPHS_ASSERT_NEXT(a_count_hold, !clear_take, insert_count >= $past(insert_count), "count fell")
  `QPHS_ASSERT(a_out_from_push, $rose(out_valid) |-> ($past(state) == ST_PUSH), "stray result")

endmodule

// ===== bench/tb_top.sv =====
// testbench for the quadratic probe hash set: self-checking, random idling
`timescale 1ns / 1ps

module tb_top;
  import qphs_pkg::*;

  localparam int CYCLE_LIMIT = 1_000_000;
  localparam int LONG_HOLD   = 400;
  localparam int SETTLE      = 200;
  localparam int PHASE_ITEMS = 65;
  localparam int SAT_PAIRS   = 270;

  typedef struct {
    status_t           status;
    logic [SLOT_W-1:0] slot;
    logic [COUNT_W-1:0] fill;
    logic              over;
  } set_result_t;

  // shadow of the hash set: works out the result of each accepted request
  class set_tracker;
    logic [KEY_BITS-1:0] slot_keys [128];
    mark_t               slot_marks [128];
    int unsigned         inserts_done;
    logic [SIZE_W-1:0]   size_reg;
    set_result_t         pending_results [$];
    int                  errors;

    function new();
      foreach (slot_keys[i]) begin
        slot_keys[i]  = '0;
        slot_marks[i] = MARK_EMPTY;
      end
      inserts_done = 0;
      size_reg     = SIZE_RESET;
      errors       = 0;
    endfunction

    function void set_size(logic [SIZE_W-1:0] value);
      size_reg = value;
    endfunction

    // table size clamped to the slots that exist
    function int unsigned slots_in_use();
      int unsigned span;
      span = size_reg;
      if (span < 1) span = 1;
      if (span > 128) span = 128;
      return span;
    endfunction

    function int unsigned pending();
      return pending_results.size();
    endfunction

    function void note_request(kind_t req_kind, logic [KEY_BITS-1:0] req_key);
      int unsigned span, pos, step, bound, last_pos;
      bit          stopped, active;
      set_result_t res;
      span     = slots_in_use();
      last_pos = 0;
      stopped  = 0;
      res.status = STATUS_OK;
      if (req_kind == KIND_CLEAR) begin
        foreach (slot_marks[i]) slot_marks[i] = MARK_EMPTY;
        inserts_done = 0;
      end else begin
        // quadratic probe: offsets 1, 3, 5 ... bounded to half the table plus one
        pos   = req_key % span;
        step  = 1;
        bound = span / 2 + 1;
        for (int unsigned i = 0; i < bound && !stopped; i++) begin
          last_pos = pos;
          if (slot_marks[pos] == MARK_EMPTY || slot_keys[pos] == req_key) begin
            stopped = 1;
          end else begin
            pos  = (pos + step) % span;
            step = step + 2;
          end
        end
        if (!stopped) begin
          res.status = STATUS_NO_SLOT;
        end else begin
          active = (slot_marks[last_pos] == MARK_ACTIVE);
          case (req_kind)
            KIND_LOOKUP: begin
              res.status = active ? STATUS_OK : STATUS_REFUSED;
            end
            KIND_INSERT: begin
              if (active) begin
                res.status = STATUS_REFUSED;
              end else begin
                slot_keys[last_pos]  = req_key;
                slot_marks[last_pos] = MARK_ACTIVE;
                if (inserts_done < 255) inserts_done++;
              end
            end
            default: begin
              if (active) slot_marks[last_pos] = MARK_DELETED;
              else res.status = STATUS_REFUSED;
            end
          endcase
        end
      end
      res.slot = last_pos[SLOT_W-1:0];
      res.fill = inserts_done[COUNT_W-1:0];
      res.over = (inserts_done > span / 2);
      pending_results.push_back(res);
    endfunction

    function void check_result(logic [1:0] got_status, logic [SLOT_W-1:0] got_slot,
                               logic [COUNT_W-1:0] got_fill, logic got_over);
      set_result_t exp;
      if (pending_results.size() == 0) begin
        $error("result with no request outstanding: status %0d slot %0d",
               got_status, got_slot);
        errors++;
        return;
      end
      exp = pending_results.pop_front();
      if (got_status !== exp.status) begin
        $error("status: expected %0d, got %0d", exp.status, got_status);
        errors++;
      end
      if (got_slot !== exp.slot) begin
        $error("slot: expected %0d, got %0d", exp.slot, got_slot);
        errors++;
      end
      if (got_fill !== exp.fill) begin
        $error("fill_count: expected %0d, got %0d", exp.fill, got_fill);
        errors++;
      end
      if (got_over !== exp.over) begin
        $error("over_half: expected %0d, got %0d", exp.over, got_over);
        errors++;
      end
    endfunction
  endclass

  logic                clk;
  logic                rst;
  logic                in_valid;
  logic                in_stall;
  logic [1:0]          kind;
  logic [KEY_BITS-1:0] key;
  logic                out_valid;
  logic                out_stall;
  logic [1:0]          status;
  logic [SLOT_W-1:0]   slot;
  logic [COUNT_W-1:0]  fill_count;
  logic                over_half;
  logic                cfg_valid;
  logic                cfg_ready;
  logic [SIZE_W-1:0]   table_size;

  set_tracker tracker;
  int         send_idle_pct;
  int         recv_idle_pct;
  int         hold_requests;

  quadratic_probe_hash_set dut (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .kind       (kind),
    .key        (key),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .status     (status),
    .slot       (slot),
    .fill_count (fill_count),
    .over_half  (over_half),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .table_size (table_size)
  );

  // clock
  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // watchdog
  initial begin : watchdog
    int cycle_count;
    cycle_count = 0;
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("CHECK FAILED");
    $finish;
  end

  // result side: random stall, plus a long hold-off when asked for
  initial begin : result_sink
    int hold_left;
    int hold_seen;
    hold_left = 0;
    hold_seen = 0;
    out_stall <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_seen != hold_requests) begin
        hold_seen = hold_requests;
        hold_left = LONG_HOLD;
      end
      if (hold_left > 0) begin
        out_stall <= 1'b1;
        hold_left--;
      end else begin
        out_stall <= ($urandom_range(99) < recv_idle_pct);
      end
    end
  end

  // monitor: check results and note accepted requests on the same edge
  always @(posedge clk) begin
    if (!rst) begin
      if (out_valid && !out_stall) tracker.check_result(status, slot, fill_count, over_half);
      if (in_valid && !in_stall) tracker.note_request(kind_t'(kind), key);
    end
  end

  // offer one request, with random gaps ahead of it, and wait for acceptance
  task automatic send_request(kind_t req_kind, logic [KEY_BITS-1:0] req_key);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    kind     <= req_kind;
    key      <= req_key;
    do @(posedge clk); while (in_stall);
  endtask

  // stop offering and wait until every result has come back
  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (tracker.pending() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_size(logic [SIZE_W-1:0] value);
    cfg_valid  <= 1'b1;
    table_size <= value;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    tracker.set_size(value);
  endtask

  function automatic kind_t pick_kind();
    int r;
    r = $urandom_range(99);
    if (r < 3) return KIND_CLEAR;
    if (r < 45) return KIND_INSERT;
    if (r < 72) return KIND_REMOVE;
    return KIND_LOOKUP;
  endfunction

  // keys mostly from a small pool so that probes collide and the table fills
  function automatic logic [KEY_BITS-1:0] pick_key(int unsigned span);
    int          r;
    int unsigned j;
    r = $urandom_range(99);
    j = $urandom_range(span + span / 2 + 2);
    if (r < 10) return $urandom;
    if (r < 15) return 32'hFFFF_FFFF - $urandom_range(3);
    if (r < 50) return j * span + $urandom_range(1);
    return j;
  endfunction

  // stimulus
  initial begin : stimulus
    logic [SIZE_W-1:0] size_plan [15];
    logic [KEY_BITS-1:0] k;
    size_plan = '{8'd3, 8'd128, 8'd7, 8'd255, 8'd13, 8'd0, 8'd31, 8'd1,
                  8'd2, 8'd61, 8'd10, 8'd127, 8'd101, 8'd64, 8'd5};
    tracker       = new();
    send_idle_pct = 33;
    recv_idle_pct = 53;
    hold_requests = 0;
    rst        <= 1'b1;
    in_valid   <= 1'b0;
    kind       <= KIND_LOOKUP;
    key        <= '0;
    cfg_valid  <= 1'b0;
    table_size <= SIZE_RESET;
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed: size after reset, collisions, lazy removal, reuse of a deleted slot
    send_request(KIND_LOOKUP, 32'd0);
    send_request(KIND_INSERT, 32'd0);
    send_request(KIND_INSERT, 32'd0);
    send_request(KIND_LOOKUP, 32'd0);
    send_request(KIND_INSERT, 32'hFFFF_FFFF);
    send_request(KIND_LOOKUP, 32'hFFFF_FFFF);
    send_request(KIND_INSERT, 32'd101);
    send_request(KIND_INSERT, 32'd202);
    send_request(KIND_REMOVE, 32'd101);
    send_request(KIND_LOOKUP, 32'd202);
    send_request(KIND_LOOKUP, 32'd101);
    send_request(KIND_INSERT, 32'd101);
    send_request(KIND_REMOVE, 32'hFFFF_FFFF);
    send_request(KIND_REMOVE, 32'hFFFF_FFFF);
    send_request(KIND_LOOKUP, 32'd5);
    send_request(KIND_CLEAR, 32'hA5A5_5A5A);
    send_request(KIND_LOOKUP, 32'd0);
    send_request(KIND_REMOVE, 32'd0);
    drain();

    // directed: table size three, probe bound runs out
    write_size(8'd3);
    send_request(KIND_INSERT, 32'd0);
    send_request(KIND_INSERT, 32'd3);
    send_request(KIND_INSERT, 32'd6);
    send_request(KIND_LOOKUP, 32'd6);
    send_request(KIND_REMOVE, 32'd6);
    send_request(KIND_INSERT, 32'd2);
    drain();

    // random phases across sizes, idling patterns swapped part way and then turned off
    for (int ph = 0; ph < 15; ph++) begin
      if (ph < 5) begin
        send_idle_pct = 33;
        recv_idle_pct = 53;
      end else if (ph < 10) begin
        send_idle_pct = 53;
        recv_idle_pct = 33;
      end else begin
        send_idle_pct = 0;
        recv_idle_pct = 0;
      end
      write_size(size_plan[ph]);
      // long hold-off on the result side while requests keep coming
      if (ph == 11) hold_requests++;
      for (int n = 0; n < PHASE_ITEMS; n++)
        send_request(pick_kind(), pick_key(tracker.slots_in_use()));
      drain();
    end

    // insert and remove the same keys over and over until the count saturates
    write_size(8'd37);
    send_request(KIND_CLEAR, $urandom);
    for (int n = 0; n < SAT_PAIRS; n++) begin
      k = $urandom_range(15) * 37;
      send_request(KIND_INSERT, k);
      send_request(KIND_REMOVE, k);
    end
    drain();
    repeat (SETTLE) @(posedge clk);

    if (tracker.errors == 0 && tracker.pending() == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
